// ----- rtl/gbte_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the gap buffer text editor.
package gbte_pkg;

   localparam int STORE_DEPTH_DEF = 512;

   localparam int CMD_W  = 3;
   localparam int POS_W  = 10;
   localparam int CHAR_W = 8;
   localparam int ST_W   = 2;

   localparam logic [CMD_W-1:0] CMD_READ_AT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PREV    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MOVE_TO = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd6;

   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [POS_W-1:0]  amount;
      logic [CHAR_W-1:0] in_char;
      logic              insert_last;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic [ST_W-1:0]   status;
      logic [POS_W-1:0]  cursor_pos;
      logic [POS_W-1:0]  text_len;
   } rsp_payload_type;

endpackage

// ----- rtl/gbte_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces.
interface gbte_req_if;
   logic                         valid;
   logic                         ready;
   logic [gbte_pkg::CMD_W-1:0]   cmd;
   logic [gbte_pkg::POS_W-1:0]   amount;
   logic [gbte_pkg::CHAR_W-1:0]  in_char;
   logic                         insert_last;

   modport source (output valid, output cmd, output amount, output in_char,
                   output insert_last, input ready);
   modport sink (input valid, input cmd, input amount, input in_char,
                 input insert_last, output ready);
endinterface

interface gbte_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gbte_pkg::CHAR_W-1:0]  out_char;
   logic [gbte_pkg::ST_W-1:0]    status;
   logic [gbte_pkg::POS_W-1:0]   cursor_pos;
   logic [gbte_pkg::POS_W-1:0]   text_len;

   modport source (output valid, output out_char, output status, output cursor_pos,
                   output text_len, input ready);
   modport sink (input valid, input out_char, input status, input cursor_pos,
                 input text_len, output ready);
endinterface

// ----- rtl/gbte_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gbte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/gbte_rsp_reg.sv -----
`timescale 1ns / 1ps
// Response output register.
module gbte_rsp_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  gbte_pkg::rsp_payload_type data,
   output logic                      free,
   gbte_rsp_if.source                rsp_ch
);

   logic                      valid_ff;
   logic                      valid_in;
   gbte_pkg::rsp_payload_type data_ff;
   gbte_pkg::rsp_payload_type data_in;

   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = data;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.out_char   = data_ff.out_char;
   assign rsp_ch.status     = data_ff.status;
   assign rsp_ch.cursor_pos = data_ff.cursor_pos;
   assign rsp_ch.text_len   = data_ff.text_len;

endmodule

// ----- rtl/gbte_core.sv -----
`timescale 1ns / 1ps
// Command sequencer: cursor counts, gap walks and in-place reversal on the store.
module gbte_core #(
   parameter int DEPTH = gbte_pkg::STORE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  gbte_pkg::req_payload_type     req_data,
   output logic                          mem_we,
   output logic [$clog2(DEPTH)-1:0]      mem_waddr,
   output logic [gbte_pkg::CHAR_W-1:0]   mem_wdata,
   output logic [$clog2(DEPTH)-1:0]      mem_raddr,
   input  logic [gbte_pkg::CHAR_W-1:0]   mem_rdata,
   input  logic                          rsp_free,
   output logic                          rsp_load,
   output gbte_pkg::rsp_payload_type     rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > gbte_pkg::POS_W) ? CW : gbte_pkg::POS_W) + 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_REV  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [CW-1:0]               bc_ff, bc_in;
   logic [CW-1:0]               ac_ff, ac_in;
   logic [CW-1:0]               pend_ff, pend_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        back_ff, back_in;
   logic                        wpend_ff, wpend_in;
   logic [AW-1:0]               wdst_ff, wdst_in;
   logic [AW-1:0]               lo_ff, lo_in;
   logic [AW-1:0]               hi_ff, hi_in;
   logic [AW-1:0]               lo_prev_ff, lo_prev_in;
   logic [AW-1:0]               hi_prev_ff, hi_prev_in;
   logic [gbte_pkg::CHAR_W-1:0] lo_data_ff, lo_data_in;
   logic                        phase_ff, phase_in;
   logic                        pvalid_ff, pvalid_in;
   logic [gbte_pkg::ST_W-1:0]   status_ff, status_in;
   logic [gbte_pkg::CHAR_W-1:0] char_ff, char_in;

   logic [XW-1:0] bc_x, ac_x, len_x, amt_x, depth_x, pend_x;
   logic [XW-1:0] ins_bc_x, ins_pend_x, ins_n_x;
   logic          full;
   logic          rev_act;

   assign bc_x     = XW'(bc_ff);
   assign ac_x     = XW'(ac_ff);
   assign len_x    = bc_x + ac_x;
   assign amt_x    = XW'(req_data.amount);
   assign depth_x  = XW'(DEPTH);
   assign pend_x   = XW'(pend_ff);
   assign full     = len_x >= depth_x;
   assign ins_bc_x   = full ? bc_x : bc_x + XW'(1);
   assign ins_pend_x = full ? pend_x : pend_x + XW'(1);
   assign ins_n_x    = (ins_pend_x > ins_bc_x) ? ins_bc_x : ins_pend_x;
   assign rev_act  = lo_ff < hi_ff;

   assign req_ready = (state_ff == S_IDLE);

   assign rsp_data.out_char   = char_ff;
   assign rsp_data.status     = status_ff;
   assign rsp_data.cursor_pos = gbte_pkg::POS_W'(bc_x);
   assign rsp_data.text_len   = gbte_pkg::POS_W'(len_x);

   always_comb begin
      state_in   = state_ff;
      bc_in      = bc_ff;
      ac_in      = ac_ff;
      pend_in    = pend_ff;
      cnt_in     = cnt_ff;
      back_in    = back_ff;
      wpend_in   = wpend_ff;
      wdst_in    = wdst_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      lo_prev_in = lo_prev_ff;
      hi_prev_in = hi_prev_ff;
      lo_data_in = lo_data_ff;
      phase_in   = phase_ff;
      pvalid_in  = pvalid_ff;
      status_in  = status_ff;
      char_in    = char_ff;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = '0;
      mem_raddr  = '0;
      rsp_load   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.cmd != gbte_pkg::CMD_INSERT) begin
                  pend_in = '0;
               end
               status_in = gbte_pkg::ST_DONE;
               char_in   = '0;
               state_in  = S_DONE;
               unique case (req_data.cmd)
                  gbte_pkg::CMD_READ_AT: begin
                     if (amt_x >= len_x) begin
                        status_in = gbte_pkg::ST_RANGE;
                     end else begin
                        mem_raddr = (amt_x < bc_x) ? AW'(amt_x)
                                                   : AW'(amt_x + depth_x - len_x);
                        state_in  = S_READ;
                     end
                  end
                  gbte_pkg::CMD_PREV: begin
                     if (bc_ff == '0) begin
                        status_in = gbte_pkg::ST_RANGE;
                     end else begin
                        cnt_in   = CW'(1);
                        back_in  = 1'b1;
                        state_in = S_WALK;
                     end
                  end
                  gbte_pkg::CMD_NEXT: begin
                     if (ac_ff == '0) begin
                        status_in = gbte_pkg::ST_RANGE;
                     end else begin
                        cnt_in   = CW'(1);
                        back_in  = 1'b0;
                        state_in = S_WALK;
                     end
                  end
                  gbte_pkg::CMD_MOVE_TO: begin
                     if (amt_x > len_x) begin
                        status_in = gbte_pkg::ST_RANGE;
                     end else if (amt_x < bc_x) begin
                        cnt_in   = CW'(bc_x - amt_x);
                        back_in  = 1'b1;
                        state_in = S_WALK;
                     end else begin
                        cnt_in   = CW'(amt_x - bc_x);
                        back_in  = 1'b0;
                        state_in = S_WALK;
                     end
                  end
                  gbte_pkg::CMD_INSERT: begin
                     if (full) begin
                        status_in = gbte_pkg::ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(bc_x);
                        mem_wdata = req_data.in_char;
                     end
                     bc_in   = CW'(ins_bc_x);
                     pend_in = CW'(ins_pend_x);
                     if (req_data.insert_last) begin
                        // return the cursor to where the insertion began
                        cnt_in   = CW'(ins_n_x);
                        back_in  = 1'b1;
                        pend_in  = '0;
                        state_in = S_WALK;
                     end
                  end
                  gbte_pkg::CMD_DELETE: begin
                     if (amt_x > ac_x) begin
                        status_in = gbte_pkg::ST_RANGE;
                     end else begin
                        ac_in = CW'(ac_x - amt_x);
                     end
                  end
                  gbte_pkg::CMD_REVERSE: begin
                     if (amt_x > ac_x) begin
                        status_in = gbte_pkg::ST_RANGE;
                     end else if (amt_x > XW'(1)) begin
                        lo_in     = AW'(depth_x - ac_x);
                        hi_in     = AW'(depth_x - ac_x + amt_x - XW'(1));
                        phase_in  = 1'b0;
                        pvalid_in = 1'b0;
                        state_in  = S_REV;
                     end
                  end
                  default: begin
                     status_in = gbte_pkg::ST_RANGE;
                  end
               endcase
            end
         end
         S_READ: begin
            char_in  = mem_rdata;
            state_in = S_DONE;
         end
         S_WALK: begin
            // read one char per cycle, write it across the gap the next cycle
            if (wpend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wdst_ff;
               mem_wdata = mem_rdata;
            end
            if (cnt_ff != '0) begin
               cnt_in   = cnt_ff - CW'(1);
               wpend_in = 1'b1;
               if (back_ff) begin
                  mem_raddr = AW'(bc_x - XW'(1));
                  wdst_in   = AW'(depth_x - ac_x - XW'(1));
                  bc_in     = CW'(bc_x - XW'(1));
                  ac_in     = CW'(ac_x + XW'(1));
               end else begin
                  mem_raddr = AW'(depth_x - ac_x);
                  wdst_in   = AW'(bc_x);
                  bc_in     = CW'(bc_x + XW'(1));
                  ac_in     = CW'(ac_x - XW'(1));
               end
            end else begin
               wpend_in = 1'b0;
               state_in = S_DONE;
            end
         end
         S_REV: begin
            // phase 0: low write of previous pair, read low; phase 1: high write, read high
            if (!phase_ff) begin
               if (pvalid_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = lo_prev_ff;
                  mem_wdata = mem_rdata;
               end
               if (rev_act) begin
                  mem_raddr = lo_ff;
               end
               phase_in = 1'b1;
            end else begin
               if (pvalid_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = hi_prev_ff;
                  mem_wdata = lo_data_ff;
               end
               phase_in = 1'b0;
               if (rev_act) begin
                  lo_data_in = mem_rdata;
                  mem_raddr  = hi_ff;
                  lo_prev_in = lo_ff;
                  hi_prev_in = hi_ff;
                  lo_in      = lo_ff + AW'(1);
                  hi_in      = hi_ff - AW'(1);
                  pvalid_in  = 1'b1;
               end else begin
                  pvalid_in = 1'b0;
                  state_in  = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         bc_ff     <= '0;
         ac_ff     <= '0;
         pend_ff   <= '0;
         cnt_ff    <= '0;
         wpend_ff  <= 1'b0;
         phase_ff  <= 1'b0;
         pvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bc_ff     <= bc_in;
         ac_ff     <= ac_in;
         pend_ff   <= pend_in;
         cnt_ff    <= cnt_in;
         wpend_ff  <= wpend_in;
         phase_ff  <= phase_in;
         pvalid_ff <= pvalid_in;
      end
      back_ff    <= back_in;
      wdst_ff    <= wdst_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      lo_prev_ff <= lo_prev_in;
      hi_prev_ff <= hi_prev_in;
      lo_data_ff <= lo_data_in;
      status_ff  <= status_in;
      char_ff    <= char_in;
   end

endmodule

// ----- rtl/gap_buffer_text_editor.sv -----
`timescale 1ns / 1ps
// Gap buffer text editor top level.
//
//   channel   direction  transfer when         payload
//   req_ch    in         valid && ready        cmd, amount, in_char, insert_last
//   rsp_ch    out        valid && ready        out_char, status, cursor_pos, text_len
//
// One command at a time. Prev, next, move_to and the end of an insert walk characters
// across the gap, and reverse of n >= 2 characters swaps them in place; the single
// write port of the store moves one character per cycle.
// Reset clears cursor and length counts; the store itself is not cleared.
// A stalled response is held in the output register while the next command runs.
module gap_buffer_text_editor #(
   parameter int STORE_DEPTH = gbte_pkg::STORE_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   gbte_req_if.sink    req_ch,
   gbte_rsp_if.source  rsp_ch
);

   localparam int AW = $clog2(STORE_DEPTH);

   gbte_pkg::req_payload_type   req_data;
   gbte_pkg::rsp_payload_type   rsp_data;
   logic                        rsp_load;
   logic                        rsp_free;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [gbte_pkg::CHAR_W-1:0] mem_wdata;
   logic [AW-1:0]               mem_raddr;
   logic [gbte_pkg::CHAR_W-1:0] mem_rdata;

   assign req_data.cmd         = req_ch.cmd;
   assign req_data.amount      = req_ch.amount;
   assign req_data.in_char     = req_ch.in_char;
   assign req_data.insert_last = req_ch.insert_last;

   gbte_core #(
      .DEPTH(STORE_DEPTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_data  (req_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .rsp_free  (rsp_free),
      .rsp_load  (rsp_load),
      .rsp_data  (rsp_data)
   );

   gbte_ram #(
      .WIDTH(gbte_pkg::CHAR_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   gbte_rsp_reg u_rsp (
      .clock  (clock),
      .reset  (reset),
      .load   (rsp_load),
      .data   (rsp_data),
      .free   (rsp_free),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- rtl/gbte_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the gap buffer text editor, bound to the top level.
module gbte_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [gbte_pkg::CHAR_W-1:0] rsp_out_char,
   input logic [gbte_pkg::ST_W-1:0]   rsp_status,
   input logic [gbte_pkg::POS_W-1:0]  rsp_cursor_pos,
   input logic [gbte_pkg::POS_W-1:0]  rsp_text_len
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) &&
      $stable(rsp_status) && $stable(rsp_cursor_pos) && $stable(rsp_text_len))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == gbte_pkg::ST_DONE || rsp_status == gbte_pkg::ST_RANGE ||
      rsp_status == gbte_pkg::ST_FULL)
      else $error("undefined status code");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != gbte_pkg::ST_DONE |-> rsp_out_char == '0)
      else $error("character returned with a failing status");

endmodule

bind gap_buffer_text_editor gbte_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_char   (rsp_ch.out_char),
   .rsp_status     (rsp_ch.status),
   .rsp_cursor_pos (rsp_ch.cursor_pos),
   .rsp_text_len   (rsp_ch.text_len)
);

// ----- tb/gap_buffer_text_editor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the gap buffer text editor: scoreboard class plus drivers.
module gap_buffer_text_editor_tb;

   localparam int DEPTH       = gbte_pkg::STORE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int LINGER      = 1100;
   localparam logic [gbte_pkg::CMD_W-1:0] CMD_UNKNOWN = 3'd7;

   class text_scoreboard;
      logic [gbte_pkg::CHAR_W-1:0] text_cells [DEPTH];
      int head_len;
      int tail_len;
      int open_insert_len;
      gbte_pkg::rsp_payload_type expected_replies [$];
      int mismatches;
      int replies_seen;
      int full_refusals;
      int rejects;
      int cmd_tally [8];

      function new();
         foreach (text_cells[i]) text_cells[i] = '0;
         foreach (cmd_tally[i]) cmd_tally[i] = 0;
         head_len = 0;
         tail_len = 0;
         open_insert_len = 0;
         mismatches = 0;
         replies_seen = 0;
         full_refusals = 0;
         rejects = 0;
      endfunction

      // one character from before the cursor to after it
      function void shift_back();
         text_cells[DEPTH - tail_len - 1] = text_cells[head_len - 1];
         head_len--;
         tail_len++;
      endfunction

      function void shift_fwd();
         text_cells[head_len] = text_cells[DEPTH - tail_len];
         head_len++;
         tail_len--;
      endfunction

      function void note_command(gbte_pkg::req_payload_type r);
         gbte_pkg::rsp_payload_type exp;
         int len;
         int amt;
         int lo;
         int hi;
         logic [gbte_pkg::CHAR_W-1:0] t;
         len = head_len + tail_len;
         amt = int'(r.amount);
         exp = '0;
         exp.status = gbte_pkg::ST_DONE;
         if (r.cmd != gbte_pkg::CMD_INSERT) open_insert_len = 0;
         case (r.cmd)
            gbte_pkg::CMD_READ_AT: begin
               if (amt >= len) exp.status = gbte_pkg::ST_RANGE;
               else if (amt < head_len) exp.out_char = text_cells[amt];
               else exp.out_char = text_cells[DEPTH - tail_len + amt - head_len];
            end
            gbte_pkg::CMD_PREV: begin
               if (head_len == 0) exp.status = gbte_pkg::ST_RANGE;
               else shift_back();
            end
            gbte_pkg::CMD_NEXT: begin
               if (tail_len == 0) exp.status = gbte_pkg::ST_RANGE;
               else shift_fwd();
            end
            gbte_pkg::CMD_MOVE_TO: begin
               if (amt > len) exp.status = gbte_pkg::ST_RANGE;
               else begin
                  while (head_len > amt) shift_back();
                  while (head_len < amt) shift_fwd();
               end
            end
            gbte_pkg::CMD_INSERT: begin
               if (len >= DEPTH) begin
                  exp.status = gbte_pkg::ST_FULL;
                  full_refusals++;
               end else begin
                  text_cells[head_len] = r.in_char;
                  head_len++;
                  open_insert_len++;
               end
               if (r.insert_last) begin
                  lo = (open_insert_len > head_len) ? head_len : open_insert_len;
                  repeat (lo) shift_back();
                  open_insert_len = 0;
               end
            end
            gbte_pkg::CMD_DELETE: begin
               if (amt > tail_len) exp.status = gbte_pkg::ST_RANGE;
               else tail_len -= amt;
            end
            gbte_pkg::CMD_REVERSE: begin
               if (amt > tail_len) exp.status = gbte_pkg::ST_RANGE;
               else if (amt > 1) begin
                  lo = DEPTH - tail_len;
                  hi = lo + amt - 1;
                  while (lo < hi) begin
                     t = text_cells[lo];
                     text_cells[lo] = text_cells[hi];
                     text_cells[hi] = t;
                     lo++;
                     hi--;
                  end
               end
            end
            default: exp.status = gbte_pkg::ST_RANGE;
         endcase
         if (exp.status == gbte_pkg::ST_RANGE) rejects++;
         exp.cursor_pos = gbte_pkg::POS_W'(head_len);
         exp.text_len = gbte_pkg::POS_W'(head_len + tail_len);
         cmd_tally[r.cmd]++;
         expected_replies.push_back(exp);
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 30) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_reply(gbte_pkg::rsp_payload_type got);
         gbte_pkg::rsp_payload_type want;
         replies_seen++;
         if (expected_replies.size() == 0) begin
            report($sformatf("reply %0d with nothing outstanding: char %h st %0d cur %0d len %0d",
                             replies_seen, got.out_char, got.status, got.cursor_pos,
                             got.text_len));
         end else begin
            want = expected_replies.pop_front();
            if (got.out_char !== want.out_char || got.status !== want.status ||
                got.cursor_pos !== want.cursor_pos || got.text_len !== want.text_len)
               report($sformatf("reply %0d: got char %h st %0d cur %0d len %0d, want %h %0d %0d %0d",
                                replies_seen, got.out_char, got.status, got.cursor_pos,
                                got.text_len, want.out_char, want.status, want.cursor_pos,
                                want.text_len));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   gbte_req_if req_ch();
   gbte_rsp_if rsp_ch();
   text_scoreboard sb = new();
   int items_sent = 0;
   bit calm = 1'b0;
   int cycles = 0;

   gap_buffer_text_editor #(.STORE_DEPTH(DEPTH)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_cmd(logic [gbte_pkg::CMD_W-1:0] cmd, int amt,
                           logic [gbte_pkg::CHAR_W-1:0] ch, bit last);
      gbte_pkg::req_payload_type item;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= cmd;
      req_ch.amount      <= gbte_pkg::POS_W'(amt);
      req_ch.in_char     <= ch;
      req_ch.insert_last <= last;
      do @(posedge clock); while (!req_ch.ready);
      item.cmd         = cmd;
      item.amount      = gbte_pkg::POS_W'(amt);
      item.in_char     = ch;
      item.insert_last = last;
      sb.note_command(item);
      items_sent++;
   endtask

   // unused fields carry random noise
   task automatic send_plain(logic [gbte_pkg::CMD_W-1:0] cmd, int amt);
      send_cmd(cmd, amt, gbte_pkg::CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic insert_run(int n, bit close);
      for (int k = 0; k < n; k++)
         send_cmd(gbte_pkg::CMD_INSERT, $urandom_range(0, 1023),
                  gbte_pkg::CHAR_W'($urandom_range(0, 255)), close && k == n - 1);
   endtask

   task automatic wait_all_replies();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_replies.size() != 0);
   endtask

   task automatic random_edit();
      int pick;
      int len;
      int tail;
      pick = $urandom_range(0, 99);
      len = sb.head_len + sb.tail_len;
      tail = sb.tail_len;
      if (pick < 40) insert_run($urandom_range(1, 10), $urandom_range(0, 6) != 0);
      else if (pick < 52)
         send_plain(gbte_pkg::CMD_READ_AT, len > 0 ? $urandom_range(0, len - 1) : 0);
      else if (pick < 56) send_plain(gbte_pkg::CMD_READ_AT, $urandom_range(len, 1023));
      else if (pick < 61) send_plain(gbte_pkg::CMD_PREV, $urandom_range(0, 1023));
      else if (pick < 66) send_plain(gbte_pkg::CMD_NEXT, $urandom_range(0, 1023));
      else if (pick < 74) send_plain(gbte_pkg::CMD_MOVE_TO, $urandom_range(0, len));
      else if (pick < 76) send_plain(gbte_pkg::CMD_MOVE_TO, $urandom_range(len, 1023));
      else if (pick < 84)
         send_plain(gbte_pkg::CMD_DELETE, $urandom_range(0, tail < 4 ? tail : 4));
      else if (pick < 86) send_plain(gbte_pkg::CMD_DELETE, $urandom_range(tail, 1023));
      else if (pick < 94) send_plain(gbte_pkg::CMD_REVERSE, $urandom_range(0, tail));
      else if (pick < 96) send_plain(gbte_pkg::CMD_REVERSE, $urandom_range(tail, 1023));
      else if (pick < 98) send_plain(CMD_UNKNOWN, $urandom_range(0, 1023));
      else begin
         // insertion cut short by an arbitrary command
         insert_run($urandom_range(1, 3), 1'b0);
         send_plain(gbte_pkg::CMD_W'($urandom_range(0, 7)), $urandom_range(0, 1023));
      end
   endtask

   // response side back-pressure
   initial begin
      int pick;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         pick = $urandom_range(0, 99);
         if (calm) rsp_ch.ready <= 1'b1;
         else if (pick < 6) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (pick < 9) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(30, 150)) @(posedge clock);
         end else rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      gbte_pkg::rsp_payload_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.out_char   = rsp_ch.out_char;
         got.status     = rsp_ch.status;
         got.cursor_pos = rsp_ch.cursor_pos;
         got.text_len   = rsp_ch.text_len;
         sb.check_reply(got);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      int finish_at;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= gbte_pkg::CMD_READ_AT;
      req_ch.amount      <= '0;
      req_ch.in_char     <= '0;
      req_ch.insert_last <= 1'b0;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty buffer corner cases, then edits on a short text
      send_plain(gbte_pkg::CMD_READ_AT, 0);
      send_plain(gbte_pkg::CMD_PREV, 0);
      send_plain(gbte_pkg::CMD_NEXT, 0);
      send_plain(gbte_pkg::CMD_MOVE_TO, 1);
      send_plain(gbte_pkg::CMD_DELETE, 1);
      send_plain(gbte_pkg::CMD_REVERSE, 0);
      send_plain(CMD_UNKNOWN, 1023);
      send_cmd(gbte_pkg::CMD_INSERT, 0, 8'h00, 1'b0);
      send_cmd(gbte_pkg::CMD_INSERT, 1023, 8'hFF, 1'b0);
      send_cmd(gbte_pkg::CMD_INSERT, 512, 8'hA5, 1'b1);
      send_plain(gbte_pkg::CMD_READ_AT, 2);
      send_plain(gbte_pkg::CMD_READ_AT, 3);
      send_plain(gbte_pkg::CMD_NEXT, 0);
      send_cmd(gbte_pkg::CMD_INSERT, 0, 8'h5A, 1'b0);
      send_plain(gbte_pkg::CMD_PREV, 0);
      send_plain(gbte_pkg::CMD_REVERSE, sb.tail_len);
      send_plain(gbte_pkg::CMD_REVERSE, sb.tail_len + 1);
      send_plain(gbte_pkg::CMD_DELETE, 0);
      send_plain(gbte_pkg::CMD_MOVE_TO, sb.head_len + sb.tail_len);
      send_plain(gbte_pkg::CMD_MOVE_TO, 0);
      send_plain(gbte_pkg::CMD_DELETE, 1);
      send_plain(gbte_pkg::CMD_READ_AT, 0);

      while (items_sent < 35) begin
         if ($urandom_range(0, 99) == 0) wait_all_replies();
         random_edit();
      end

      // fill to the brim in one open insertion, overflow, then close while full
      wait_all_replies();
      send_plain(gbte_pkg::CMD_MOVE_TO, $urandom_range(0, sb.head_len + sb.tail_len));
      while (sb.head_len + sb.tail_len < DEPTH)
         send_cmd(gbte_pkg::CMD_INSERT, $urandom_range(0, 1023),
                  gbte_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0);
      insert_run(3, 1'b1);
      send_plain(gbte_pkg::CMD_NEXT, 0);
      insert_run(1, 1'b1);
      send_plain(gbte_pkg::CMD_MOVE_TO, DEPTH);
      send_plain(gbte_pkg::CMD_READ_AT, DEPTH - 1);
      send_plain(gbte_pkg::CMD_READ_AT, DEPTH);
      send_plain(gbte_pkg::CMD_NEXT, 0);
      send_plain(gbte_pkg::CMD_MOVE_TO, 0);
      send_plain(gbte_pkg::CMD_PREV, 0);
      send_plain(gbte_pkg::CMD_REVERSE, DEPTH);
      send_plain(gbte_pkg::CMD_READ_AT, 0);
      send_plain(gbte_pkg::CMD_MOVE_TO, DEPTH / 2);
      send_plain(gbte_pkg::CMD_DELETE, sb.tail_len);

      finish_at = items_sent + 35;
      while (items_sent < finish_at) begin
         if (finish_at - items_sent < 15) calm = 1'b1;
         else if ($urandom_range(0, 99) == 0) wait_all_replies();
         random_edit();
      end

      req_ch.valid <= 1'b0;
      while (sb.expected_replies.size() != 0) @(posedge clock);
      repeat (LINGER) @(posedge clock);

      $display("Run covered %0d commands: %0d inserts, %0d moves, %0d reverses, %0d deletes.",
               items_sent, sb.cmd_tally[gbte_pkg::CMD_INSERT], sb.cmd_tally[gbte_pkg::CMD_MOVE_TO],
               sb.cmd_tally[gbte_pkg::CMD_REVERSE], sb.cmd_tally[gbte_pkg::CMD_DELETE]);
      $display("%0d rejected as out of range, %0d inserts refused by a full store, %0d mismatches.",
               sb.rejects, sb.full_refusals, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_replies.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/gbte_pkg.sv
rtl/gbte_if.sv
rtl/gbte_ram.sv
rtl/gbte_rsp_reg.sv
rtl/gbte_core.sv
rtl/gap_buffer_text_editor.sv
rtl/gbte_checker.sv
tb/gap_buffer_text_editor_tb.sv
